### rtl/epcal_pkg.sv
`default_nettype none

package epcal_pkg;

  // Widths of the working values.
  localparam int TimeW     = 33;  // local seconds, epoch plus up to fifteen hours
  localparam int DivW      = 17;  // divisor and remainder, covers seconds per day
  localparam int DaysW     = 16;  // whole days since the epoch
  localparam int MinOfDayW = 11;  // minutes within the day
  localparam int CntW      = 1;   // divider stage count
  localparam int YearW     = 8;   // year counted from 1900
  localparam int YdayW     = 9;   // day within the year

  // Reciprocal division. Seconds are first shifted right by seven, since a day
  // is 675 times 128 seconds, so the multiplier operand stays at 26 bits.
  localparam int DayShift   = 7;
  localparam int MulAW      = TimeW - DayShift;
  localparam int MulBW      = 27;
  localparam int ProdW      = MulAW + MulBW;
  localparam int RecipDay   = 101806633;  // 2^36 / 675, rounded up
  localparam int RecipMin   = 139811;     // 2^23 / 60, rounded up
  localparam int RecipWeek  = 149797;     // 2^20 / 7, rounded up
  localparam int DayQuoLsb  = 36;
  localparam int MinQuoLsb  = 23;
  localparam int WeekQuoLsb = 20;

  localparam int SecsPerDay   = 86400;
  localparam int SecsPerHour  = 3600;
  localparam int SecsPerMin   = 60;
  localparam int DaysPerWeek  = 7;
  localparam int EpochYear    = 70;   // 1970 counted from 1900
  localparam int EpochWeekday = 4;    // the epoch fell on a Thursday
  localparam int NonLeapCent  = 200;  // 2100, the one skipped century in range
  localparam int DaysPerYear  = 365;
  localparam int DaysPerLeap  = 366;
  localparam int LastFebNorm  = 58;   // day of year of Feb 28
  localparam int LeapDay      = 59;   // day of year of Feb 29 in a leap year

  localparam logic [YdayW-1:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Divisions carried out in turn by the shared divider.
  typedef enum logic [1:0] {
    DIV_DAY  = 2'd0,
    DIV_SEC  = 2'd1,
    DIV_MIN  = 2'd2,
    DIV_WEEK = 2'd3
  } div_op_t;

  typedef struct packed {
    logic    load_input;
    logic    div_load;
    logic    div_step;
    logic    div_store;
    div_op_t div_op;
    logic    year_step;
    logic    out_load;
  } ep_cmd_t;

  typedef struct packed {
    logic div_last;
    logic year_done;
    logic out_free;
  } ep_status_t;

  typedef struct packed {
    logic [3:0] mon;
    logic [4:0] mday;
  } month_t;

  function automatic logic [DivW-1:0] div_divisor(input div_op_t op);
    case (op)
      DIV_DAY:  return DivW'(SecsPerDay);
      DIV_SEC:  return DivW'(SecsPerMin);
      DIV_MIN:  return DivW'(SecsPerMin);
      DIV_WEEK: return DivW'(DaysPerWeek);
      default:  return DivW'(SecsPerDay);
    endcase
  endfunction

  // Each reciprocal is exact over the whole operand range of its division.
  function automatic logic [MulBW-1:0] div_recip(input div_op_t op);
    case (op)
      DIV_DAY:  return MulBW'(RecipDay);
      DIV_SEC:  return MulBW'(RecipMin);
      DIV_MIN:  return MulBW'(RecipMin);
      DIV_WEEK: return MulBW'(RecipWeek);
      default:  return MulBW'(RecipDay);
    endcase
  endfunction

  // Years 1970 through 2106 only; 2000 is a leap year, 2100 is not.
  function automatic logic is_leap(input logic [YearW-1:0] yr);
    return (yr[1:0] == 2'b00) && (yr != YearW'(NonLeapCent));
  endfunction

  function automatic month_t month_split(input logic [YdayW-1:0] yday, input logic leap);
    logic [YdayW-1:0] d;
    logic [3:0]       mon;
    logic [4:0]       mday;
    month_t           r;
    mday = 5'd1;
    d    = yday;
    if (leap && (yday > YdayW'(LastFebNorm))) begin
      if (yday == YdayW'(LeapDay)) begin
        mday = 5'd2;
      end
      d = yday - YdayW'(1);
    end
    mon = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (MONTH_START[i] <= d) begin
        mon = 4'(i);
      end
    end
    mday   = mday + 5'(d - MONTH_START[mon]);
    r.mon  = mon;
    r.mday = mday;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/epcal_ctrl.sv
`default_nettype none

module epcal_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  epcal_pkg::ep_status_t status,
  output epcal_pkg::ep_cmd_t    cmd
);
  import epcal_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOAD   = 5'b00010,
    S_RUN    = 5'b00100,
    S_YEARS  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t  state, state_next;
  div_op_t op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= DIV_DAY;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.div_op = op;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_input = 1'b1;
          op_next        = DIV_DAY;
          state_next     = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_RUN;
      end
      S_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.div_store = 1'b1;
          if (op == DIV_WEEK) begin
            state_next = S_YEARS;
          end else begin
            op_next    = div_op_t'(op + 2'd1);
            state_next = S_LOAD;
          end
        end
      end
      S_YEARS: begin
        cmd.year_step = 1'b1;
        if (status.year_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/epcal_dpath.sv
`default_nettype none

module epcal_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic signed [4:0]     timezone_hours,
  input  logic [31:0]           epoch_seconds,
  input  epcal_pkg::ep_cmd_t    cmd,
  output epcal_pkg::ep_status_t status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [5:0]            second,
  output logic [5:0]            minute,
  output logic [4:0]            hour,
  output logic [2:0]            weekday,
  output logic [7:0]            year_since_1900,
  output logic [8:0]            day_of_year,
  output logic [3:0]            month,
  output logic [4:0]            day_of_month,
  output logic                  clamped
);
  import epcal_pkg::*;

  logic signed [4:0]  tz;
  logic signed [17:0] offset;
  logic signed [33:0] local_secs;

  logic [TimeW-1:0]     secs;
  logic                 clamp;
  logic [ProdW-1:0]     prod;
  logic [DaysW-1:0]     quo;
  logic [CntW-1:0]      count;
  logic [DaysW-1:0]     days;
  logic [DivW-1:0]      sod;
  logic [MinOfDayW-1:0] mod_min;
  logic [5:0]           sec_w;
  logic [5:0]           min_w;
  logic [4:0]           hour_w;
  logic [2:0]           wday_w;
  logic [YearW-1:0]     yr;

  logic [DivW-1:0]  divisor;
  logic [MulAW-1:0] mul_a;
  logic [DaysW-1:0] quo_calc;
  logic [DivW-1:0]  rem_calc;
  logic [TimeW-1:0] dividend;
  logic [YdayW-1:0] year_len;
  logic             year_done;
  logic             leap;
  month_t           md;

  always_ff @(posedge clk) begin
    if (rst) begin
      tz <= 5'sd8;
    end else if (cfg_write) begin
      tz <= timezone_hours;
    end
  end

  // Local time; a negative sum saturates to the epoch.
  assign offset     = 18'(tz) * 18'sd3600;
  assign local_secs = $signed({2'b00, epoch_seconds}) + 34'(offset);

  always_comb begin
    case (cmd.div_op)
      DIV_DAY:  dividend = secs;
      DIV_SEC:  dividend = TimeW'(sod);
      DIV_MIN:  dividend = TimeW'(mod_min);
      DIV_WEEK: dividend = TimeW'({1'b0, days} + (DaysW + 1)'(EpochWeekday));
      default:  dividend = secs;
    endcase
  end

  // Division by a constant through a reciprocal. The product is registered in
  // the load state, the quotient is registered from it in the run state, and
  // the remainder is formed from that registered quotient as the run state ends.
  assign divisor  = div_divisor(cmd.div_op);
  assign mul_a    = (cmd.div_op == DIV_DAY) ? dividend[TimeW-1:DayShift]
                                            : dividend[MulAW-1:0];
  assign rem_calc = dividend[DivW-1:0] - (DivW'(quo) * divisor);

  always_comb begin
    case (cmd.div_op)
      DIV_DAY:  quo_calc = prod[DayQuoLsb +: DaysW];
      DIV_SEC:  quo_calc = prod[MinQuoLsb +: DaysW];
      DIV_MIN:  quo_calc = prod[MinQuoLsb +: DaysW];
      DIV_WEEK: quo_calc = prod[WeekQuoLsb +: DaysW];
      default:  quo_calc = prod[DayQuoLsb +: DaysW];
    endcase
  end

  assign leap      = is_leap(yr);
  assign year_len  = leap ? YdayW'(DaysPerLeap) : YdayW'(DaysPerYear);
  assign year_done = (days < DaysW'(year_len));
  assign md        = month_split(days[YdayW-1:0], leap);

  always_ff @(posedge clk) begin
    if (cmd.load_input) begin
      clamp <= local_secs[33];
      secs  <= local_secs[33] ? '0 : local_secs[TimeW-1:0];
      yr    <= YearW'(EpochYear);
    end
    if (cmd.div_load) begin
      prod  <= ProdW'(mul_a) * ProdW'(div_recip(cmd.div_op));
      count <= CntW'(1);
    end else if (cmd.div_step) begin
      quo   <= quo_calc;
      count <= count - CntW'(1);
    end
    if (cmd.div_store) begin
      case (cmd.div_op)
        DIV_DAY: begin
          days <= quo;
          sod  <= rem_calc;
        end
        DIV_SEC: begin
          sec_w   <= rem_calc[5:0];
          mod_min <= quo[MinOfDayW-1:0];
        end
        DIV_MIN: begin
          min_w  <= rem_calc[5:0];
          hour_w <= quo[4:0];
        end
        DIV_WEEK: begin
          wday_w <= rem_calc[2:0];
        end
        default: begin
          wday_w <= rem_calc[2:0];
        end
      endcase
    end else if (cmd.year_step && !year_done) begin
      days <= days - DaysW'(year_len);
      yr   <= yr + YearW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      second          <= sec_w;
      minute          <= min_w;
      hour            <= hour_w;
      weekday         <= wday_w;
      year_since_1900 <= yr;
      day_of_year     <= days[YdayW-1:0];
      month           <= md.mon;
      day_of_month    <= md.mday;
      clamped         <= clamp;
    end
  end

  assign status.div_last  = (count == '0);
  assign status.year_done = year_done;
  assign status.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

### rtl/epoch_seconds_to_calendar.sv
`default_nettype none

// Channel   Handshake              Payload
// config    cfg_write              timezone_hours (signed hours)
// input     in_valid / in_ready    epoch_seconds
// output    out_valid / out_ready  second, minute, hour, weekday, year_since_1900,
//                                  day_of_year, month, day_of_month, clamped
//
// From acceptance to a loaded result, a word passes through four divisions by
// constants, each a reciprocal multiplication, then the year walk, one year per
// cycle over the N whole years from 1970 to the local date (at most 136), and
// the final load.
// Reset (rst, synchronous) empties the output register and sets the offset to +8 h.
// A finished word waits in the output register; the next input word is taken
// meanwhile, and only the final load stalls if the previous word is still unread.

module epoch_seconds_to_calendar (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic signed [4:0] timezone_hours,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       epoch_seconds,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [5:0]        second,
  output logic [5:0]        minute,
  output logic [4:0]        hour,
  output logic [2:0]        weekday,
  output logic [7:0]        year_since_1900,
  output logic [8:0]        day_of_year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month,
  output logic              clamped
);
  import epcal_pkg::*;

  ep_cmd_t    cmd;
  ep_status_t status;

  // The controller sequences the word: capture, four divisions (seconds into days,
  // seconds of day into minutes, minutes into hours, days into weekday), the year
  // walk, and the final load that also resolves month and day of month.
  epcal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the offset register, the divider, the year counter and the
  // output register.
  epcal_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .timezone_hours  (timezone_hours),
    .epoch_seconds   (epoch_seconds),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .second          (second),
    .minute          (minute),
    .hour            (hour),
    .weekday         (weekday),
    .year_since_1900 (year_since_1900),
    .day_of_year     (day_of_year),
    .month           (month),
    .day_of_month    (day_of_month),
    .clamped         (clamped)
  );

  // Once a word is taken, the block is busy on the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("input still ready right after a word was taken");

  // A saturated local time must come out as the epoch itself.
  a_clamp_is_epoch: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && clamped) |->
      (second == 6'd0 && minute == 6'd0 && hour == 5'd0 && weekday == 3'd4 &&
       year_since_1900 == 8'd70 && day_of_year == 9'd0 && month == 4'd0 &&
       day_of_month == 5'd1)
  ) else $error("clamped result is not 1970-01-01 00:00:00");

  // Calendar fields stay within their ranges.
  a_fields_in_range: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> (day_of_month != 5'd0 && month < 4'd12 && weekday < 3'd7 &&
                   hour < 5'd24 && minute < 6'd60 && second < 6'd60)
  ) else $error("calendar field out of range");

endmodule

`default_nettype wire
